// ===== src/stafp_pkg.sv =====
// package for the slot table: sizes, entry layout, opcodes and helpers
// used by stafp_store and slot_table_alloc_find_progress
package stafp_pkg;

  localparam int SLOTS  = 128;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = SLOT_W + 1;
  localparam int RES_W  = 7;

  localparam logic [1:0] OP_CLEAR    = 2'd0;
  localparam logic [1:0] OP_REGISTER = 2'd1;
  localparam logic [1:0] OP_FIND     = 2'd2;
  localparam logic [1:0] OP_ADVANCE  = 2'd3;

  localparam logic [7:0] TYPE_FREE = 8'd0;
  localparam logic [7:0] TRACK_A   = 8'h0B;
  localparam logic [7:0] TRACK_B   = 8'd19;
  localparam logic [7:0] TRACK_C   = 8'h17;
  localparam logic [7:0] TRACK_D   = 8'h1C;
  localparam logic [7:0] TRACK_E   = 8'd40;

  typedef struct packed {
    logic [7:0]  kind;
    logic [31:0] owner;
    logic [31:0] progress;
  } entry_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    entry_t            data;
  } wr_req_t;

  function automatic logic trackable(input logic [7:0] t);
    return (t == TRACK_A) || (t == TRACK_B) || (t == TRACK_C) ||
           (t == TRACK_D) || (t == TRACK_E);
  endfunction

  function automatic logic [RES_W-1:0] to_res(input logic [SLOT_W-1:0] a);
    logic [SLOT_W+RES_W-1:0] w;
    w = {{RES_W{1'b0}}, a};
    return w[RES_W-1:0];
  endfunction

endpackage

// ===== src/stafp_store.sv =====
// slot store: one synchronous memory of entries with a registered read port
// and per-slot valid bits so that clear frees every slot at once; uses stafp_pkg
module stafp_store import stafp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              clr,
  input  logic              rd_en,
  input  logic [SLOT_W-1:0] rd_addr,
  output entry_t            rd_entry,
  input  wr_req_t           wr
);

  entry_t            mem [SLOTS];
  logic [SLOTS-1:0]  vld;
  entry_t            rd_raw;
  logic              rd_vld;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_raw <= mem[rd_addr];
      rd_vld <= vld[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      vld <= '0;
    end else if (wr.en) begin
      vld[wr.addr] <= 1'b1;
    end
  end

  // a never-written slot reads as free
  always_comb begin
    rd_entry      = rd_raw;
    rd_entry.kind = rd_vld ? rd_raw.kind : TYPE_FREE;
  end

endmodule

// ===== src/slot_table_alloc_find_progress.sv =====
// Slot table with allocation, lookup by owner and progress counting; built on
// stafp_store and stafp_pkg. One request is taken at a time and gives one result.
// Clear works on acceptance, as does register in single-slot mode. Register and
// find walk the slot memory one slot a cycle through its single read port, ending
// early on the first hit. Advance reads the indexed slot if in range, then bumps
// its progress if its kind matches a tracked request type. The response state
// hands the result to the output register once that can take it, after which the
// next request is taken while it waits. Clear frees all slots at once via valid bits.
module slot_table_alloc_find_progress import stafp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [31:0] owner,
  input  logic [7:0]  type_code,
  input  logic [6:0]  slot_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        ok,
  output logic [6:0]  result_slot
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_ADV  = 2'd2;
  localparam logic [1:0] S_RESP = 2'd3;

  logic [1:0]        state, state_next;
  logic              single_slot_mode;
  logic [1:0]        op_q;
  logic [31:0]       owner_q;
  logic [7:0]        type_q;
  logic [CNT_W-1:0]  issue_addr, issue_addr_next;
  logic              chk_valid, chk_valid_next;
  logic [SLOT_W-1:0] chk_addr;
  logic              res_ok, res_ok_next;
  logic [RES_W-1:0]  res_slot, res_slot_next;

  logic              clr;
  logic              rd_en;
  logic [SLOT_W-1:0] rd_addr;
  entry_t            rd_entry;
  wr_req_t           wr;
  logic              accept;
  logic              idx_in_range;
  logic              hit;

  stafp_store u_store (
    .clk      (clk),
    .rst      (rst),
    .clr      (clr),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_entry (rd_entry),
    .wr       (wr)
  );

  assign in_stall     = (state != S_IDLE);
  assign accept       = in_valid && !in_stall;
  assign idx_in_range = ({25'd0, slot_index} < 32'(SLOTS));

  always_comb begin
    if (op_q == OP_REGISTER) begin
      hit = (rd_entry.kind == TYPE_FREE);
    end else begin
      hit = (rd_entry.kind != TYPE_FREE) && (rd_entry.owner == owner_q);
    end
  end

  always_comb begin
    state_next      = state;
    issue_addr_next = issue_addr;
    chk_valid_next  = chk_valid;
    res_ok_next     = res_ok;
    res_slot_next   = res_slot;
    clr             = 1'b0;
    rd_en           = 1'b0;
    rd_addr         = issue_addr[SLOT_W-1:0];
    wr              = '0;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          res_ok_next   = 1'b0;
          res_slot_next = '0;
          unique case (opcode)
            OP_CLEAR: begin
              clr         = 1'b1;
              res_ok_next = 1'b1;
              state_next  = S_RESP;
            end
            OP_ADVANCE: begin
              if (idx_in_range) begin
                rd_en      = 1'b1;
                rd_addr    = SLOT_W'(slot_index);
                state_next = S_ADV;
              end else begin
                state_next = S_RESP;
              end
            end
            default: begin
              if (opcode == OP_REGISTER && single_slot_mode) begin
                wr.en       = 1'b1;
                wr.addr     = '0;
                wr.data     = '{kind: type_code, owner: owner, progress: 32'd0};
                res_ok_next = 1'b1;
                state_next  = S_RESP;
              end else begin
                issue_addr_next = '0;
                chk_valid_next  = 1'b0;
                state_next      = S_SCAN;
              end
            end
          endcase
        end
      end

      S_SCAN: begin
        if (issue_addr < CNT_W'(SLOTS)) begin
          rd_en           = 1'b1;
          issue_addr_next = issue_addr + 1'b1;
        end
        chk_valid_next = rd_en;
        if (chk_valid) begin
          if (hit) begin
            if (op_q == OP_REGISTER) begin
              wr.en   = 1'b1;
              wr.addr = chk_addr;
              wr.data = '{kind: type_q, owner: owner_q, progress: 32'd0};
            end
            res_ok_next    = 1'b1;
            res_slot_next  = to_res(chk_addr);
            chk_valid_next = 1'b0;
            state_next     = S_RESP;
          end else if (chk_addr == SLOT_W'(SLOTS - 1)) begin
            chk_valid_next = 1'b0;
            state_next     = S_RESP;
          end
        end
      end

      S_ADV: begin
        if (rd_entry.kind != TYPE_FREE && trackable(type_q)) begin
          res_ok_next = 1'b1;
          if (rd_entry.kind == type_q) begin
            wr.en   = 1'b1;
            wr.addr = chk_addr;
            wr.data = '{kind: rd_entry.kind, owner: rd_entry.owner,
                        progress: rd_entry.progress + 32'd1};
          end
        end
        state_next = S_RESP;
      end

      S_RESP: begin
        if (!out_valid || !out_stall) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      single_slot_mode <= 1'b0;
      chk_valid        <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      state     <= state_next;
      chk_valid <= chk_valid_next;
      if (cfg_wr_en) begin
        single_slot_mode <= cfg_wr_data;
      end
      if (state == S_RESP && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // request fields, scan pointers and result payload
  always_ff @(posedge clk) begin
    issue_addr <= issue_addr_next;
    res_ok     <= res_ok_next;
    res_slot   <= res_slot_next;
    if (rd_en) begin
      chk_addr <= rd_addr;
    end
    if (accept) begin
      op_q    <= opcode;
      owner_q <= owner;
      type_q  <= type_code;
    end
    if (state == S_RESP && (!out_valid || !out_stall)) begin
      ok          <= res_ok;
      result_slot <= res_slot;
    end
  end

  a_scan_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && chk_valid) |-> ({1'b0, chk_addr} < issue_addr))
    else $error("scan check slot not behind issue pointer");

  a_single_slot: assert property (@(posedge clk) disable iff (rst)
    (state == S_RESP && op_q == OP_REGISTER && single_slot_mode) |-> (res_slot == '0))
    else $error("single-slot register gave a nonzero slot");

  a_fail_slot: assert property (@(posedge clk) disable iff (rst)
    (state == S_RESP && !res_ok) |-> (res_slot == '0))
    else $error("failed request carries a nonzero slot");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// self-checking bench for slot_table_alloc_find_progress: directed table, then random phases
// with varied idling, each result checked against scripted answers or an in-bench slot table predictor
// depends on stafp_pkg and the rtl of slot_table_alloc_find_progress
module tb_top;
  import stafp_pkg::*;

  localparam logic [1:0] CFG_KEEP = 2'd0;
  localparam logic [1:0] CFG_OFF  = 2'd2;
  localparam logic [1:0] CFG_ON   = 2'd3;

  typedef struct packed {
    logic [1:0]  cfg;
    logic [1:0]  op;
    logic [31:0] own;
    logic [7:0]  kind;
    logic [6:0]  idx;
    logic        typed;
    logic        ok;
    logic [6:0]  slot;
  } step_t;

  typedef struct packed {
    logic       ok;
    logic [6:0] slot;
  } answer_t;

  localparam step_t SCRIPT [0:25] = '{
    '{CFG_KEEP, OP_FIND,     32'h0000_0000, TYPE_FREE, 7'd0,   1'b1, 1'b0, 7'd0},
    '{CFG_KEEP, OP_ADVANCE,  32'h0000_0000, TRACK_A,   7'd0,   1'b1, 1'b0, 7'd0},
    '{CFG_KEEP, OP_REGISTER, 32'h8000_0000, 8'hFF,     7'd0,   1'b0, 1'b0, 7'd0},
    '{CFG_KEEP, OP_REGISTER, 32'h7FFF_FFFF, TRACK_A,   7'd127, 1'b0, 1'b0, 7'd0},
    '{CFG_KEEP, OP_REGISTER, 32'h0000_0000, TYPE_FREE, 7'd0,   1'b0, 1'b0, 7'd0},
    '{CFG_KEEP, OP_REGISTER, 32'hFFFF_FFFF, TRACK_E,   7'd0,   1'b0, 1'b0, 7'd0},
    '{CFG_KEEP, OP_FIND,     32'h7FFF_FFFF, TYPE_FREE, 7'd0,   1'b0, 1'b0, 7'd0},
    '{CFG_KEEP, OP_FIND,     32'hFFFF_FFFF, TYPE_FREE, 7'd0,   1'b0, 1'b0, 7'd0},
    '{CFG_KEEP, OP_FIND,     32'h0000_0000, TYPE_FREE, 7'd0,   1'b0, 1'b0, 7'd0},
    '{CFG_KEEP, OP_FIND,     32'h8000_0000, TYPE_FREE, 7'd0,   1'b0, 1'b0, 7'd0},
    '{CFG_KEEP, OP_ADVANCE,  32'h0000_0000, TRACK_A,   7'd1,   1'b0, 1'b0, 7'd0},
    '{CFG_KEEP, OP_ADVANCE,  32'h0000_0000, TRACK_B,   7'd1,   1'b0, 1'b0, 7'd0},
    '{CFG_KEEP, OP_ADVANCE,  32'h0000_0000, 8'hFF,     7'd0,   1'b1, 1'b0, 7'd0},
    '{CFG_KEEP, OP_ADVANCE,  32'h0000_0000, TRACK_C,   7'd127, 1'b1, 1'b0, 7'd0},
    '{CFG_KEEP, OP_ADVANCE,  32'h0000_0000, TRACK_D,   7'd2,   1'b0, 1'b0, 7'd0},
    '{CFG_KEEP, OP_ADVANCE,  32'h0000_0000, TRACK_E,   7'd2,   1'b0, 1'b0, 7'd0},
    '{CFG_KEEP, OP_REGISTER, 32'h0000_0005, TRACK_C,   7'd0,   1'b0, 1'b0, 7'd0},
    '{CFG_KEEP, OP_CLEAR,    32'hFFFF_FFFF, 8'hFF,     7'd127, 1'b1, 1'b1, 7'd0},
    '{CFG_KEEP, OP_FIND,     32'h7FFF_FFFF, TYPE_FREE, 7'd0,   1'b1, 1'b0, 7'd0},
    '{CFG_ON,   OP_REGISTER, 32'h0000_0009, TRACK_D,   7'd0,   1'b0, 1'b0, 7'd0},
    '{CFG_KEEP, OP_REGISTER, 32'h0000_000A, TRACK_B,   7'd0,   1'b0, 1'b0, 7'd0},
    '{CFG_KEEP, OP_FIND,     32'h0000_0009, TYPE_FREE, 7'd0,   1'b0, 1'b0, 7'd0},
    '{CFG_KEEP, OP_FIND,     32'h0000_000A, TYPE_FREE, 7'd0,   1'b0, 1'b0, 7'd0},
    '{CFG_KEEP, OP_REGISTER, 32'h0000_000B, TYPE_FREE, 7'd0,   1'b0, 1'b0, 7'd0},
    '{CFG_KEEP, OP_FIND,     32'h0000_000B, TYPE_FREE, 7'd0,   1'b0, 1'b0, 7'd0},
    '{CFG_OFF,  OP_REGISTER, 32'h0000_000C, TRACK_C,   7'd0,   1'b0, 1'b0, 7'd0}
  };

  localparam int PHASE_SEND_IDLE [0:3] = '{0, 77, 0, 11};
  localparam int PHASE_STALL [0:3]     = '{0, 0, 77, 11};
  localparam bit PHASE_MODE [0:3]      = '{1'b0, 1'b0, 1'b1, 1'b0};
  localparam int PHASE_ITEMS = 225;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_wr_data = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  opcode = OP_CLEAR;
  logic [31:0] owner = '0;
  logic [7:0]  type_code = '0;
  logic [6:0]  slot_index = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        ok;
  logic [6:0]  result_slot;

  logic [7:0]  tbl_kind [SLOTS];
  logic [31:0] tbl_owner [SLOTS];
  logic [31:0] tbl_progress [SLOTS];
  logic        solo_mode;

  answer_t     pending_answers [$];
  logic [31:0] owner_pool [16];
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          mismatches = 0;

  slot_table_alloc_find_progress dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .opcode      (opcode),
    .owner       (owner),
    .type_code   (type_code),
    .slot_index  (slot_index),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .ok          (ok),
    .result_slot (result_slot)
  );

  always #2 clk = ~clk;

  function automatic logic [7:0] pick_tracked();
    logic [7:0] kinds [5];
    kinds = '{TRACK_A, TRACK_B, TRACK_C, TRACK_D, TRACK_E};
    return kinds[$urandom_range(0, 4)];
  endfunction

  function automatic answer_t table_apply(input logic [1:0] op, input logic [31:0] own,
                                          input logic [7:0] kind, input logic [6:0] idx);
    answer_t a;
    int      pick;
    a = '0;
    pick = -1;
    case (op)
      OP_CLEAR: begin
        for (int i = 0; i < SLOTS; i++) begin
          tbl_kind[i] = TYPE_FREE;
          tbl_owner[i] = '0;
          tbl_progress[i] = '0;
        end
        a.ok = 1'b1;
      end
      OP_REGISTER: begin
        if (solo_mode) pick = 0;
        else
          for (int i = 0; i < SLOTS; i++)
            if (pick < 0 && tbl_kind[i] == TYPE_FREE) pick = i;
        if (pick >= 0) begin
          tbl_kind[pick] = kind;
          tbl_owner[pick] = own;
          tbl_progress[pick] = '0;
          a.ok = 1'b1;
          a.slot = pick[6:0];
        end
      end
      OP_FIND: begin
        for (int i = 0; i < SLOTS; i++)
          if (pick < 0 && tbl_kind[i] != TYPE_FREE && tbl_owner[i] == own) pick = i;
        if (pick >= 0) begin
          a.ok = 1'b1;
          a.slot = pick[6:0];
        end
      end
      default: begin
        if (int'(idx) < SLOTS && tbl_kind[idx] != TYPE_FREE &&
            kind inside {TRACK_A, TRACK_B, TRACK_C, TRACK_D, TRACK_E}) begin
          if (tbl_kind[idx] == kind) tbl_progress[idx] = tbl_progress[idx] + 32'd1;
          a.ok = 1'b1;
        end
      end
    endcase
    return a;
  endfunction

  task automatic send_request(input logic [1:0] op, input logic [31:0] own,
                              input logic [7:0] kind, input logic [6:0] idx,
                              input logic typed, input answer_t typed_answer);
    answer_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    owner <= own;
    type_code <= kind;
    slot_index <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = table_apply(op, own, kind, idx);
    pending_answers.push_back(typed ? typed_answer : predicted);
  endtask

  task automatic write_mode(input logic value);
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    solo_mode = value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_random();
    logic [1:0]  op;
    logic [31:0] own;
    logic [7:0]  kind;
    logic [6:0]  idx;
    int          r;
    r = $urandom_range(0, 99);
    op = (r < 1) ? OP_CLEAR : (r < 41) ? OP_REGISTER : (r < 71) ? OP_FIND : OP_ADVANCE;
    own = ($urandom_range(0, 99) < 78) ? owner_pool[$urandom_range(0, 15)] : $urandom;
    idx = ($urandom_range(0, 99) < 60) ? 7'($urandom_range(0, 31)) : 7'($urandom_range(0, 127));
    r = $urandom_range(0, 99);
    if (op == OP_ADVANCE)
      kind = (r < 55) ? tbl_kind[idx] : (r < 85) ? pick_tracked() : 8'($urandom_range(0, 255));
    else
      kind = (r < 45) ? pick_tracked() : (r < 55) ? TYPE_FREE : 8'($urandom_range(0, 255));
    send_request(op, own, kind, idx, 1'b0, '0);
  endtask

  always @(posedge clk) begin
    answer_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_answers.size() == 0) begin
        $error("result with no request outstanding: ok=%0d result_slot=%0d", ok, result_slot);
        mismatches++;
      end else begin
        want = pending_answers.pop_front();
        if (ok !== want.ok) begin
          $error("ok: expected %0d, got %0d", want.ok, ok);
          mismatches++;
        end
        if (result_slot !== want.slot) begin
          $error("result_slot: expected %0d, got %0d", want.slot, result_slot);
          mismatches++;
        end
      end
    end
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  initial begin
    #4000000;
    $display("slot_table_alloc_find_progress regression: fail");
    $finish;
  end

  initial begin
    answer_t noted;
    int      count;
    owner_pool[0] = 32'h8000_0000;
    owner_pool[1] = 32'h7FFF_FFFF;
    owner_pool[2] = 32'h0000_0000;
    owner_pool[3] = 32'hFFFF_FFFF;
    for (int i = 4; i < 16; i++) owner_pool[i] = $urandom;
    for (int i = 0; i < SLOTS; i++) begin
      tbl_kind[i] = TYPE_FREE;
      tbl_owner[i] = '0;
      tbl_progress[i] = '0;
    end
    solo_mode = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (SCRIPT[n]) begin
      if (SCRIPT[n].cfg != CFG_KEEP) write_mode(SCRIPT[n].cfg == CFG_ON);
      noted.ok = SCRIPT[n].ok;
      noted.slot = SCRIPT[n].slot;
      send_request(SCRIPT[n].op, SCRIPT[n].own, SCRIPT[n].kind, SCRIPT[n].idx,
                   SCRIPT[n].typed, noted);
    end

    for (int p = 0; p < 4; p++) begin
      send_idle_pct = PHASE_SEND_IDLE[p];
      stall_pct = PHASE_STALL[p];
      write_mode(PHASE_MODE[p]);
      count = PHASE_ITEMS;
      if (p == 0) begin
        // fill every slot so the full-table path is hit
        send_request(OP_CLEAR, $urandom, 8'($urandom), 7'($urandom), 1'b0, '0);
        for (int i = 0; i < SLOTS; i++)
          send_request(OP_REGISTER, owner_pool[$urandom_range(0, 15)],
                       8'($urandom_range(1, 255)), 7'($urandom), 1'b0, '0);
        count = PHASE_ITEMS - SLOTS - 1;
      end
      for (int i = 0; i < count; i++) send_random();
    end

    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("slot_table_alloc_find_progress regression: pass");
    end else begin
      $display("slot_table_alloc_find_progress regression: fail");
    end
    $finish;
  end

endmodule

// ===== slot_table_alloc_find_progress.f =====
src/stafp_pkg.sv
src/stafp_store.sv
src/slot_table_alloc_find_progress.sv
bench/tb_top.sv
